// ===== rtl/core/adsr_pkg.sv =====
// ----------------------------------------------------------------------------
// adsr_pkg: shared types and constants of the adsr envelope gain unit
// widths, operation codes, register map and controller/datapath bundles
// ----------------------------------------------------------------------------
package adsr_pkg;

    // field widths
    localparam int SAMPLE_BITS     = 24;
    localparam int LEVEL_FRAC_BITS = 24;
    localparam int LEVEL_BITS      = LEVEL_FRAC_BITS + 1;
    localparam int LEN_BITS        = 17;
    localparam int IDX_BITS        = 18;
    localparam int OP_BITS         = 2;
    localparam int ADDR_BITS       = 5;
    localparam int DATA_BITS       = 32;
    localparam int REG_SEL_BITS    = 3;
    localparam int SLOPE_BITS      = LEVEL_BITS + 1;
    localparam int DIV_CNT_BITS    = 5;
    localparam int IN_DATA_BITS    = 2 * SAMPLE_BITS;
    localparam int OUT_DATA_BITS   = 80;

    // value limits
    localparam logic [LEVEL_BITS-1:0] FULL_SCALE  = LEVEL_BITS'(1) << LEVEL_FRAC_BITS;
    localparam logic [LEN_BITS-1:0]   MAX_SEG_LEN = LEN_BITS'(88000);
    localparam logic [IDX_BITS-1:0]   IDX_MAX     = '1;
    localparam logic [DIV_CNT_BITS-1:0] DIV_LAST  = DIV_CNT_BITS'(LEVEL_BITS - 1);

    // operation codes
    localparam logic [OP_BITS-1:0] OP_SAMPLE   = 2'd0;
    localparam logic [OP_BITS-1:0] OP_GATE_ON  = 2'd1;
    localparam logic [OP_BITS-1:0] OP_GATE_OFF = 2'd2;

    // register indexes
    localparam logic [REG_SEL_BITS-1:0] REG_ATTACK_LEN   = 3'd0;
    localparam logic [REG_SEL_BITS-1:0] REG_DECAY_LEN    = 3'd1;
    localparam logic [REG_SEL_BITS-1:0] REG_RELEASE_LEN  = 3'd2;
    localparam logic [REG_SEL_BITS-1:0] REG_SUSTAIN      = 3'd3;
    localparam logic [REG_SEL_BITS-1:0] REG_ATTACK_STEP  = 3'd4;
    localparam logic [REG_SEL_BITS-1:0] REG_DECAY_STEP   = 3'd5;
    localparam logic [REG_SEL_BITS-1:0] REG_RELEASE_STEP = 3'd6;

    // configuration bundle
    typedef struct packed {
        logic [LEN_BITS-1:0]   attack_length;
        logic [LEN_BITS-1:0]   decay_length;
        logic [LEN_BITS-1:0]   release_length;
        logic [LEVEL_BITS-1:0] sustain_level;
        logic [LEVEL_BITS-1:0] attack_step;
        logic [LEVEL_BITS-1:0] decay_step;
        logic [LEVEL_BITS-1:0] release_step;
    } cfg_t;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic gate_on;
        logic div_start;
        logic div_step;
        logic div_end;
        logic step;
        logic mul_l;
        logic mul_r;
        logic load_out;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic div_last;
        logic out_free;
    } sts_t;

endpackage

// ===== rtl/core/adsr_regs.sv =====
// ----------------------------------------------------------------------------
// adsr_regs: configuration register file
// apb slave holding the envelope lengths, levels and steps
// ----------------------------------------------------------------------------
module adsr_regs
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [adsr_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [adsr_pkg::DATA_BITS-1:0]  pwdata,
    output logic [adsr_pkg::DATA_BITS-1:0]  prdata,
    output logic                            pready,
    output adsr_pkg::cfg_t                  cfg
);

    adsr_pkg::cfg_t                       cfg_reg;
    logic                                 wr_en;
    logic [adsr_pkg::REG_SEL_BITS-1:0]    sel;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign sel    = paddr[adsr_pkg::ADDR_BITS-1:2];
    assign cfg    = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.attack_length  <= adsr_pkg::LEN_BITS'(16053);
            cfg_reg.decay_length   <= adsr_pkg::LEN_BITS'(1);
            cfg_reg.release_length <= adsr_pkg::LEN_BITS'(1);
            cfg_reg.sustain_level  <= adsr_pkg::FULL_SCALE;
            cfg_reg.attack_step    <= adsr_pkg::LEVEL_BITS'(1045);
            cfg_reg.decay_step     <= '0;
            cfg_reg.release_step   <= adsr_pkg::FULL_SCALE;
        end
        else if (wr_en)
        begin
            case (sel)
                adsr_pkg::REG_ATTACK_LEN:
                    cfg_reg.attack_length  <= pwdata[adsr_pkg::LEN_BITS-1:0];
                adsr_pkg::REG_DECAY_LEN:
                    cfg_reg.decay_length   <= pwdata[adsr_pkg::LEN_BITS-1:0];
                adsr_pkg::REG_RELEASE_LEN:
                    cfg_reg.release_length <= pwdata[adsr_pkg::LEN_BITS-1:0];
                adsr_pkg::REG_SUSTAIN:
                    cfg_reg.sustain_level  <= pwdata[adsr_pkg::LEVEL_BITS-1:0];
                adsr_pkg::REG_ATTACK_STEP:
                    cfg_reg.attack_step    <= pwdata[adsr_pkg::LEVEL_BITS-1:0];
                adsr_pkg::REG_DECAY_STEP:
                    cfg_reg.decay_step     <= pwdata[adsr_pkg::LEVEL_BITS-1:0];
                adsr_pkg::REG_RELEASE_STEP:
                    cfg_reg.release_step   <= pwdata[adsr_pkg::LEVEL_BITS-1:0];
                default:
                    ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        case (sel)
            adsr_pkg::REG_ATTACK_LEN:
                prdata = adsr_pkg::DATA_BITS'(cfg_reg.attack_length);
            adsr_pkg::REG_DECAY_LEN:
                prdata = adsr_pkg::DATA_BITS'(cfg_reg.decay_length);
            adsr_pkg::REG_RELEASE_LEN:
                prdata = adsr_pkg::DATA_BITS'(cfg_reg.release_length);
            adsr_pkg::REG_SUSTAIN:
                prdata = adsr_pkg::DATA_BITS'(cfg_reg.sustain_level);
            adsr_pkg::REG_ATTACK_STEP:
                prdata = adsr_pkg::DATA_BITS'(cfg_reg.attack_step);
            adsr_pkg::REG_DECAY_STEP:
                prdata = adsr_pkg::DATA_BITS'(cfg_reg.decay_step);
            adsr_pkg::REG_RELEASE_STEP:
                prdata = adsr_pkg::DATA_BITS'(cfg_reg.release_step);
            default:
                prdata = '0;
        endcase
    end

endmodule

// ===== rtl/core/adsr_ctrl.sv =====
// ----------------------------------------------------------------------------
// adsr_ctrl: sequencing state machine
// accepts one transaction at a time and steps the datapath through
// envelope update, two multiplies, output load or the release divide
// ----------------------------------------------------------------------------
module adsr_ctrl
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [adsr_pkg::OP_BITS-1:0]  op,
    output logic                          in_ready,
    input  adsr_pkg::sts_t                sts,
    output adsr_pkg::cmd_t                cmd
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_STEP    = 3'd1;
    localparam logic [2:0] ST_MUL_L   = 3'd2;
    localparam logic [2:0] ST_MUL_R   = 3'd3;
    localparam logic [2:0] ST_LOAD    = 3'd4;
    localparam logic [2:0] ST_DIV     = 3'd5;
    localparam logic [2:0] ST_DIV_END = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready = (state_reg == ST_IDLE);

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (op)
                        adsr_pkg::OP_SAMPLE:
                        begin
                            cmd.capture = 1'b1;
                            state_next  = ST_STEP;
                        end
                        adsr_pkg::OP_GATE_ON:
                        begin
                            cmd.gate_on = 1'b1;
                        end
                        adsr_pkg::OP_GATE_OFF:
                        begin
                            cmd.div_start = 1'b1;
                            state_next    = ST_DIV;
                        end
                        default:
                            ;
                    endcase
                end
            end
            ST_STEP:
            begin
                cmd.step   = 1'b1;
                state_next = ST_MUL_L;
            end
            ST_MUL_L:
            begin
                cmd.mul_l  = 1'b1;
                state_next = ST_MUL_R;
            end
            ST_MUL_R:
            begin
                cmd.mul_r  = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_DIV_END;
                end
            end
            ST_DIV_END:
            begin
                cmd.div_end = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/adsr_dp.sv =====
// ----------------------------------------------------------------------------
// adsr_dp: envelope datapath
// envelope state, segment update, shared sample multiplier, restoring
// divider for the release slope, and the output register
// ----------------------------------------------------------------------------
module adsr_dp
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  adsr_pkg::cfg_t                        cfg,
    input  adsr_pkg::cmd_t                        cmd,
    output adsr_pkg::sts_t                        sts,
    input  logic [adsr_pkg::SAMPLE_BITS-1:0]      left_in,
    input  logic [adsr_pkg::SAMPLE_BITS-1:0]      right_in,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [adsr_pkg::SAMPLE_BITS-1:0]      left_scaled,
    output logic [adsr_pkg::SAMPLE_BITS-1:0]      right_scaled,
    output logic [adsr_pkg::LEVEL_BITS-1:0]       envelope_level
);

    localparam int SB = adsr_pkg::SAMPLE_BITS;
    localparam int LB = adsr_pkg::LEVEL_BITS;
    localparam int NB = adsr_pkg::LEN_BITS;
    localparam int IB = adsr_pkg::IDX_BITS;
    localparam int WB = adsr_pkg::SLOPE_BITS;
    localparam int FB = adsr_pkg::LEVEL_FRAC_BITS;

    // envelope state
    logic          gate_reg;
    logic [IB-1:0] idx_reg;
    logic [LB-1:0] level_reg;
    logic [WB-1:0] slope_reg;
    logic          slope_ok_reg;

    // sample and multiply registers
    logic [SB-1:0] left_reg;
    logic [SB-1:0] right_reg;
    logic [SB-1:0] prod_reg;
    logic [SB-1:0] left_res_reg;

    // divider registers
    logic [LB-1:0]                         quot_reg;
    logic [NB:0]                           rem_reg;
    logic [adsr_pkg::DIV_CNT_BITS-1:0]     cnt_reg;

    // output registers
    logic          out_valid_reg;
    logic [SB-1:0] out_left_reg;
    logic [SB-1:0] out_right_reg;
    logic [LB-1:0] out_level_reg;

    // combinational values
    logic [NB-1:0]   att_len;
    logic [NB-1:0]   dec_len;
    logic [NB-1:0]   rel_len;
    logic [IB-1:0]   att_end;
    logic [IB-1:0]   dec_end;
    logic [IB-1:0]   idx_bump;
    logic [LB:0]     att_sum;
    logic signed [LB+1:0] dec_sum;
    logic signed [LB+1:0] rel_sum;
    logic [WB-1:0]   rel_slope;
    logic [LB-1:0]   sus_val;
    logic [LB-1:0]   level_next;
    logic [IB-1:0]   idx_next;
    logic [NB:0]     rem_shift;
    logic            rem_ge;
    logic [SB-1:0]   mag_l;
    logic [SB-1:0]   mag_r;
    logic [SB-1:0]   mul_a;
    logic [2*SB:0]   product;

    // segment lengths clamped to the legal range
    function automatic logic [NB-1:0] clamp_len(input logic [NB-1:0] n);
        logic [NB-1:0] r;
        r = n;
        if (n == '0)
        begin
            r = NB'(1);
        end
        else if (n > adsr_pkg::MAX_SEG_LEN)
        begin
            r = adsr_pkg::MAX_SEG_LEN;
        end
        return r;
    endfunction

    // saturate a signed sum to zero .. full scale
    function automatic logic [LB-1:0] sat_signed(input logic signed [LB+1:0] v);
        logic [LB-1:0] r;
        r = v[LB-1:0];
        if (v < 0)
        begin
            r = '0;
        end
        else if (v > $signed({2'b00, adsr_pkg::FULL_SCALE}))
        begin
            r = adsr_pkg::FULL_SCALE;
        end
        return r;
    endfunction

    assign att_len  = clamp_len(cfg.attack_length);
    assign dec_len  = clamp_len(cfg.decay_length);
    assign rel_len  = clamp_len(cfg.release_length);
    assign att_end  = IB'(att_len);
    assign dec_end  = IB'(att_len) + IB'(dec_len);
    assign idx_bump = (idx_reg == adsr_pkg::IDX_MAX) ? idx_reg : idx_reg + IB'(1);

    // segment arithmetic
    assign att_sum   = {1'b0, level_reg} + {1'b0, cfg.attack_step};
    assign dec_sum   = $signed({2'b00, level_reg})
                     + $signed({{2{cfg.decay_step[LB-1]}}, cfg.decay_step});
    assign rel_slope = slope_ok_reg ? slope_reg : {cfg.release_step[LB-1], cfg.release_step};
    assign rel_sum   = $signed({2'b00, level_reg}) + $signed({rel_slope[WB-1], rel_slope});

    // sustain: zero counts as one lsb, above full scale counts as full scale
    always_comb
    begin
        sus_val = cfg.sustain_level;
        if (cfg.sustain_level == '0)
        begin
            sus_val = LB'(1);
        end
        else if (cfg.sustain_level > adsr_pkg::FULL_SCALE)
        begin
            sus_val = adsr_pkg::FULL_SCALE;
        end
    end

    // envelope update for one sample
    always_comb
    begin
        level_next = level_reg;
        idx_next   = idx_bump;
        if (gate_reg)
        begin
            if (idx_reg < att_end)
            begin
                level_next = (att_sum > {1'b0, adsr_pkg::FULL_SCALE}) ?
                             adsr_pkg::FULL_SCALE : att_sum[LB-1:0];
            end
            else if (idx_reg == att_end)
            begin
                level_next = adsr_pkg::FULL_SCALE;
            end
            else if (idx_reg < dec_end)
            begin
                level_next = sat_signed(dec_sum);
            end
            else
            begin
                level_next = sus_val;
            end
        end
        else
        begin
            if (rel_sum < 0)
            begin
                level_next = '0;
                idx_next   = '0;
            end
            else
            begin
                level_next = sat_signed(rel_sum);
            end
        end
    end

    // envelope state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_reg     <= 1'b0;
            idx_reg      <= '0;
            level_reg    <= '0;
            slope_ok_reg <= 1'b0;
        end
        else
        begin
            if (cmd.gate_on)
            begin
                gate_reg  <= 1'b1;
                idx_reg   <= '0;
                level_reg <= '0;
            end
            else if (cmd.div_start)
            begin
                gate_reg <= 1'b0;
            end
            else if (cmd.step)
            begin
                idx_reg   <= idx_next;
                level_reg <= level_next;
            end
            if (cmd.div_end)
            begin
                slope_ok_reg <= 1'b1;
            end
        end
    end

    // restoring divider, one quotient bit per cycle
    assign rem_shift    = {rem_reg[NB-1:0], quot_reg[LB-1]};
    assign rem_ge       = (rem_shift >= {1'b0, rel_len});
    assign sts.div_last = (cnt_reg == adsr_pkg::DIV_LAST);

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            quot_reg <= level_reg;
            rem_reg  <= '0;
            cnt_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= rem_ge ? rem_shift - {1'b0, rel_len} : rem_shift;
            quot_reg <= {quot_reg[LB-2:0], rem_ge};
            cnt_reg  <= cnt_reg + adsr_pkg::DIV_CNT_BITS'(1);
        end
        if (cmd.div_end)
        begin
            slope_reg <= WB'(0) - {1'b0, quot_reg};
        end
    end

    // sample magnitudes and shared multiplier
    assign mag_l   = left_reg[SB-1]  ? SB'(0) - left_reg  : left_reg;
    assign mag_r   = right_reg[SB-1] ? SB'(0) - right_reg : right_reg;
    assign mul_a   = cmd.mul_r ? mag_r : mag_l;
    assign product = (2*SB+1)'(mul_a) * (2*SB+1)'(level_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            left_reg  <= left_in;
            right_reg <= right_in;
        end
        if (cmd.mul_l || cmd.mul_r)
        begin
            prod_reg <= product[FB+SB-1:FB];
        end
        if (cmd.mul_r)
        begin
            left_res_reg <= left_reg[SB-1] ? SB'(0) - prod_reg : prod_reg;
        end
    end

    // output register
    assign sts.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_left_reg  <= left_res_reg;
            out_right_reg <= right_reg[SB-1] ? SB'(0) - prod_reg : prod_reg;
            out_level_reg <= level_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign left_scaled    = out_left_reg;
    assign right_scaled   = out_right_reg;
    assign envelope_level = out_level_reg;

endmodule

// ===== rtl/core/adsr_envelope_gain_unit.sv =====
// ----------------------------------------------------------------------------
// adsr_envelope_gain_unit: linear adsr envelope applied as gain to stereo audio
//
// input stream s_*: tuser carries the operation (sample pair, gate on, gate
// off), tdata the left and right 24-bit samples. a sample pair advances the
// envelope one step and yields one output transaction on m_*; gate
// transactions yield nothing. the apb port holds attack, decay and release
// lengths, sustain level and the per-sample steps.
// a sample pair passes the envelope update, two passes through one shared
// 24x25 multiplier and the output load before it reaches m_tvalid. the
// unit takes one transaction at a time: s_tready stays low until it is done.
// gate on restarts the envelope; gate off runs the restoring divider, producing
// one bit of level / release_length per cycle.
// reset: envelope idle at level zero, registers at their defaults, output
// stream empty. a stalled receiver holds the output register; one more
// sample pair is accepted and computed (gate transactions still pass), then
// s_tready stays low until the result waiting on m_* is taken.
// ----------------------------------------------------------------------------
module adsr_envelope_gain_unit
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [adsr_pkg::IN_DATA_BITS-1:0]    s_tdata,   // [23:0] left_sample, [47:24] right_sample
    input  logic [adsr_pkg::OP_BITS-1:0]         s_tuser,   // [1:0] operation
    // output stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [adsr_pkg::OUT_DATA_BITS-1:0]   m_tdata,   // [23:0] left_scaled, [47:24] right_scaled,
                                                            // [72:48] envelope_level, [79:73] zero
    // configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [adsr_pkg::ADDR_BITS-1:0]       paddr,
    input  logic [adsr_pkg::DATA_BITS-1:0]       pwdata,
    output logic [adsr_pkg::DATA_BITS-1:0]       prdata,
    output logic                                 pready
);

    adsr_pkg::cfg_t cfg;
    adsr_pkg::cmd_t cmd;
    adsr_pkg::sts_t sts;

    logic [adsr_pkg::SAMPLE_BITS-1:0] left_scaled;
    logic [adsr_pkg::SAMPLE_BITS-1:0] right_scaled;
    logic [adsr_pkg::LEVEL_BITS-1:0]  envelope_level;

    // configuration registers
    adsr_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // controller
    adsr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .op       (s_tuser),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath
    adsr_dp u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .cmd            (cmd),
        .sts            (sts),
        .left_in        (s_tdata[adsr_pkg::SAMPLE_BITS-1:0]),
        .right_in       (s_tdata[adsr_pkg::IN_DATA_BITS-1:adsr_pkg::SAMPLE_BITS]),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .left_scaled    (left_scaled),
        .right_scaled   (right_scaled),
        .envelope_level (envelope_level)
    );

    // output packing
    assign m_tdata = {
        (adsr_pkg::OUT_DATA_BITS - 2*adsr_pkg::SAMPLE_BITS - adsr_pkg::LEVEL_BITS)'(0),
        envelope_level, right_scaled, left_scaled
    };

endmodule
